// ===== design/svct_pkg.sv =====
`timescale 1ns / 1ps

package svct_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 16;

    // Contents of one table cell.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } t_entry;

    // Operation that the controller broadcasts to every cell.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_COUNT,
        OP_SHIFT_DOWN
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] value;
        logic             insert;
    } t_cmd;

endpackage

// ===== design/svct_if.sv =====
`timescale 1ns / 1ps

interface svct_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [svct_pkg::KEY_W-1:0] value;
    logic                            end_of_set;

    modport source (output valid, output value, output end_of_set, input ready);
    modport sink   (input valid, input value, input end_of_set, output ready);
endinterface

interface svct_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [svct_pkg::KEY_W-1:0]   entry_key;
    logic        [svct_pkg::COUNT_W-1:0] entry_count;
    logic                              final_entry;
    logic                              dropped_keys;

    modport source (
        output valid, output entry_key, output entry_count,
        output final_entry, output dropped_keys, input ready
    );
    modport sink (
        input valid, input entry_key, input entry_count,
        input final_entry, input dropped_keys, output ready
    );
endinterface

// ===== design/sorted_value_count_table.sv =====
`timescale 1ns / 1ps
// The last item of a set sets the drain flag, and the drain then moves the first result into
// the output register as soon as that register is free.
// Throughput: one item per cycle while a set is being counted; after the last item the
// table drains one entry per cycle while the output register is free or being taken.
// The rates are set by the row of compare-and-shift cells, which both count and drain.
// Reset (synchronous, active low) empties the table and clears the dropped-key flag.

module sorted_value_count_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    svct_in_if.sink      i_item,
    svct_out_if.source   o_entry
);

    // Each cell holds one table entry. The cells below the incoming key form
    // a prefix of the row, because the row is kept in ascending order, so the
    // boundary cell either matches the key or is where the key goes.
    svct_pkg::t_entry w_cell [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_less;
    logic [TABLE_DEPTH-1:0] w_eq;

    svct_pkg::t_cmd w_cmd;

    logic r_draining;
    logic r_overflow;

    logic                           r_out_valid;
    logic [svct_pkg::KEY_W-1:0]     r_out_key;
    logic [svct_pkg::COUNT_W-1:0]   r_out_count;
    logic                           r_out_final;
    logic                           r_out_drop;

    logic w_accept;
    logic w_hit;
    logic w_full;
    logic w_drain_load;

    // Items are taken whenever the table is not draining; the drain owns the
    // row of cells until its last entry has been moved to the output register.
    assign i_item.ready = !r_draining;
    assign w_accept     = i_item.valid && !r_draining;

    assign w_hit  = |w_eq;
    assign w_full = w_cell[TABLE_DEPTH-1].valid;

    // While draining, the output register is refilled whenever it is empty or being taken.
    assign w_drain_load = r_draining && (!r_out_valid || o_entry.ready);

    always_comb begin
        w_cmd.value  = i_item.value;
        w_cmd.insert = !w_hit && !w_full;
        if (w_accept) begin
            w_cmd.op = svct_pkg::OP_COUNT;
        end else if (w_drain_load) begin
            w_cmd.op = svct_pkg::OP_SHIFT_DOWN;
        end else begin
            w_cmd.op = svct_pkg::OP_HOLD;
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        svct_pkg::t_entry w_lower;
        svct_pkg::t_entry w_upper;
        logic             w_lower_less;

        if (g == 0) begin : g_first
            // Everything below the first cell counts as smaller than any key.
            assign w_lower      = '0;
            assign w_lower_less = 1'b1;
        end else begin : g_mid
            assign w_lower      = w_cell[g-1];
            assign w_lower_less = w_less[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_body
            assign w_upper = w_cell[g+1];
        end

        svct_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_lower      (w_lower),
            .i_lower_less (w_lower_less),
            .i_upper      (w_upper),
            .o_entry      (w_cell[g]),
            .o_less       (w_less[g]),
            .o_eq         (w_eq[g])
        );
    end

    // Control: a transaction marked end_of_set is counted like any other and
    // then starts the drain. The drop flag includes a drop by that last item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining  <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_overflow <= r_overflow | (!w_hit && w_full);
                r_draining <= i_item.end_of_set;
            end

            if (w_drain_load) begin
                if (w_cell[0].valid) begin
                    r_out_valid <= 1'b1;
                    if (!w_cell[1].valid) begin
                        r_draining <= 1'b0;
                        r_overflow <= 1'b0;
                    end
                end else begin
                    // An empty table ends the drain without a result.
                    r_out_valid <= 1'b0;
                    r_draining  <= 1'b0;
                    r_overflow  <= 1'b0;
                end
            end else if (o_entry.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload; it only changes when a new entry is loaded.
    always_ff @(posedge i_clk) begin
        if (w_drain_load) begin
            r_out_key   <= w_cell[0].key;
            r_out_count <= w_cell[0].count;
            r_out_final <= !w_cell[1].valid;
            r_out_drop  <= r_overflow;
        end
    end

    assign o_entry.valid        = r_out_valid;
    assign o_entry.entry_key    = r_out_key;
    assign o_entry.entry_count  = r_out_count;
    assign o_entry.final_entry  = r_out_final;
    assign o_entry.dropped_keys = r_out_drop;

endmodule

// ===== design/svct_cell.sv =====
`timescale 1ns / 1ps

module svct_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  svct_pkg::t_cmd   i_cmd,
    input  svct_pkg::t_entry i_lower,
    input  logic            i_lower_less,
    input  svct_pkg::t_entry i_upper,
    output svct_pkg::t_entry o_entry,
    output logic            o_less,
    output logic            o_eq
);

    svct_pkg::t_entry r_entry;
    svct_pkg::t_entry n_entry;

    assign o_less  = r_entry.valid &&
                     ($signed(r_entry.key) < $signed(i_cmd.value));
    assign o_eq    = r_entry.valid && (r_entry.key == i_cmd.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            svct_pkg::OP_COUNT: begin
                if (o_eq) begin
                    if (r_entry.count != '1) begin
                        n_entry.count = r_entry.count + 1'b1;
                    end
                end else if (i_cmd.insert && !o_less) begin
                    // The first cell that is not below the new key takes it;
                    // every cell above it takes its lower neighbor.
                    if (i_lower_less) begin
                        n_entry.valid = 1'b1;
                        n_entry.key   = i_cmd.value;
                        n_entry.count = svct_pkg::COUNT_W'(1);
                    end else begin
                        n_entry = i_lower;
                    end
                end
            end
            svct_pkg::OP_SHIFT_DOWN: begin
                n_entry = i_upper;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.key   <= n_entry.key;
        r_entry.count <= n_entry.count;
    end

endmodule

// ===== design/svct_checker.sv =====
`timescale 1ns / 1ps

module svct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_end,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_key,
    input logic [15:0] i_out_count,
    input logic        i_out_final,
    input logic        i_out_drop
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_key) &&
        $stable(i_out_count) && $stable(i_out_final) && $stable(i_out_drop))
        else $error("result payload changed while stalled");

    // The last item of a set stops further input for the drain.
    a_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_end |=> !i_in_ready)
        else $error("input still taken after end of set");

    // Input is only ever refused because a set was closed.
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(i_in_ready) |-> $past(i_in_valid && i_in_end))
        else $error("input refused without an end of set");

    // A drain continues without gaps until its final entry.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_final |=> i_out_valid)
        else $error("gap inside a drained table");

endmodule

bind sorted_value_count_table svct_checker u_svct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_end    (i_item.end_of_set),
    .i_out_valid (o_entry.valid),
    .i_out_ready (o_entry.ready),
    .i_out_key   (o_entry.entry_key),
    .i_out_count (o_entry.entry_count),
    .i_out_final (o_entry.final_entry),
    .i_out_drop  (o_entry.dropped_keys)
);
